### rtl/tcc_pkg.sv
// Shared types and constants of the text console cursor engine.
// Depends on nothing; every module of the engine imports it.
`default_nettype none

package tcc_pkg;

    // Field widths of the stream payloads
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int POS_W      = 11;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);

    localparam int TAB_STOP = 8;

    // Operation codes on the input tuser
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // Control characters and the blank glyph
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

    // Command kinds decided by the front
    typedef logic [2:0] t_kind;
    localparam t_kind K_NOP     = 3'd0;
    localparam t_kind K_GLYPH   = 3'd1;
    localparam t_kind K_NEWLINE = 3'd2;
    localparam t_kind K_RETURN  = 3'd3;
    localparam t_kind K_TAB     = 3'd4;
    localparam t_kind K_CLEAR   = 3'd5;
    localparam t_kind K_READ    = 3'd6;

    // One classified command
    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] char_code;
        logic              idx_ok;
        logic [IDX_W-1:0]  cell_index;
    } t_cmd;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

### rtl/tcc_front.sv
// Front end of the console engine: takes input transactions and classifies them.
// Depends on tcc_pkg; feeds tcc_queue.
`default_nettype none

module tcc_front
    import tcc_pkg::*;
#(
    parameter int CELLS = 2000
) (
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [IN_DATA_W-1:0] i_data,   // char_code [7:0], cell_index [18:8]
    input  wire logic [OP_W-1:0]      i_user,   // op [1:0]
    input  wire t_q_status            i_q_status,
    output logic                      o_push,
    output t_cmd                      o_cmd
);

    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
    t_kind             kind;

    assign char_code  = i_data[CHAR_W-1:0];
    assign cell_index = i_data[CHAR_W +: IDX_W];

    // Accept whenever the queue has room
    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // Decide the command kind
    always_comb begin
        kind = K_NOP;
        unique case (i_user)
            OP_PUT: begin
                unique case (char_code)
                    CH_NEWLINE: kind = K_NEWLINE;
                    CH_RETURN:  kind = K_RETURN;
                    CH_TAB:     kind = K_TAB;
                    default:    kind = K_GLYPH;
                endcase
            end
            OP_CLEAR: kind = K_CLEAR;
            OP_READ:  kind = K_READ;
            OP_NONE:  kind = K_NOP;
        endcase
    end

    // Pack the command, with the range check on the read index done here
    always_comb begin
        o_cmd.kind       = kind;
        o_cmd.char_code  = char_code;
        o_cmd.idx_ok     = (IDX_W+2)'(cell_index) < (IDX_W+2)'(CELLS);
        o_cmd.cell_index = cell_index;
    end

endmodule

`default_nettype wire

### rtl/tcc_queue.sv
// Short command queue between the front and the back of the console engine.
// Depends on tcc_pkg.
`default_nettype none

module tcc_queue
    import tcc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_pop,
    output t_cmd       o_cmd,
    output t_q_status  o_status
);

    t_cmd             r_slot [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_cmd           = r_slot[r_rd_ptr];
    assign o_status.full   = r_count == (PTR_W+1)'(QDEPTH);
    assign o_status.empty  = r_count == '0;

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/tcc_back.sv
// Back end of the console engine: cursor, cell store, clear and scroll sequencer,
// result register. Depends on tcc_pkg; pulls commands from tcc_queue.
`default_nettype none

module tcc_back
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic [COLOR_W-1:0] i_cfg_data,
    input  wire t_cmd               i_cmd,
    input  wire t_q_status          i_q_status,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [POS_W-1:0]        o_cursor_position,
    output logic [CELL_W-1:0]       o_cell_value
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CA_W  = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    localparam logic [CA_W-1:0]  ROW_OFS     = CA_W'(COLUMNS);
    localparam logic [CA_W-1:0]  COPY_LAST   = CA_W'(CELLS - COLUMNS - 1);
    localparam logic [CA_W-1:0]  BLANK_FIRST = CA_W'(CELLS - COLUMNS);
    localparam logic [CA_W-1:0]  CELL_LAST   = CA_W'(CELLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(ROWS - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_COPY   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_BLANK  = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]         r_state,     n_state;
    t_cmd               r_cmd,       n_cmd;
    logic [COL_W-1:0]   r_col,       n_col;
    logic [ROW_W-1:0]   r_row,       n_row;
    logic               r_enabled,   n_enabled;
    logic [CA_W-1:0]    r_cnt,       n_cnt;
    logic               r_cp_pend,   n_cp_pend;
    logic [CA_W-1:0]    r_cp_addr,   n_cp_addr;
    logic               r_out_valid, n_out_valid;
    logic [COLOR_W-1:0] r_color;
    logic [POS_W-1:0]   r_out_pos;
    logic [CELL_W-1:0]  r_out_cell;
    logic [CELL_W-1:0]  r_rd_data;
    logic [CELL_W-1:0]  r_mem [CELLS];

    logic               mem_we;
    logic [CA_W-1:0]    mem_wa;
    logic [CELL_W-1:0]  mem_wd;
    logic               mem_re;
    logic [CA_W-1:0]    mem_ra;
    logic               load_out;
    logic [CA_W-1:0]    cur_pos;
    logic [CELL_W-1:0]  blank;
    logic [COL_W:0]     step_col;
    logic [ROW_W:0]     step_row;
    logic [ROW_W:0]     wrap_row;
    logic               wrap;
    logic               scroll;
    logic               is_put;

    assign cur_pos = CA_W'(r_row) * ROW_OFS + CA_W'(r_col);
    assign blank   = {r_color, CH_BLANK};
    assign is_put  = (r_cmd.kind == K_GLYPH) || (r_cmd.kind == K_NEWLINE)
                  || (r_cmd.kind == K_RETURN) || (r_cmd.kind == K_TAB);

    // Cursor move of a put, before wrap and scroll
    always_comb begin
        step_col = {1'b0, r_col};
        step_row = {1'b0, r_row};
        unique case (r_cmd.kind)
            K_NEWLINE: begin
                step_col = '0;
                step_row = {1'b0, r_row} + 1'b1;
            end
            K_RETURN: step_col = '0;
            K_TAB: begin
                step_col = ({1'b0, r_col} + (COL_W+1)'(TAB_STOP))
                         & ~(COL_W+1)'(TAB_STOP - 1);
            end
            K_GLYPH: step_col = {1'b0, r_col} + 1'b1;
            default: step_col = {1'b0, r_col};
        endcase
    end

    // Wrap at the end of a row, scroll past the last row
    assign wrap     = step_col >= (COL_W+1)'(COLUMNS);
    assign wrap_row = wrap ? step_row + 1'b1 : step_row;
    assign scroll   = wrap_row >= (ROW_W+1)'(ROWS);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_col       = r_col;
        n_row       = r_row;
        n_enabled   = r_enabled;
        n_cnt       = r_cnt;
        n_cp_pend   = r_cp_pend;
        n_cp_addr   = r_cp_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_wa      = r_cnt;
        mem_wd      = blank;
        mem_re      = 1'b0;
        mem_ra      = r_cnt + ROW_OFS;
        o_pop       = 1'b0;
        load_out    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESULT;
                if (r_cmd.kind == K_CLEAR) begin
                    n_col     = '0;
                    n_row     = '0;
                    n_enabled = 1'b1;
                    n_cnt     = '0;
                    n_state   = S_BLANK;
                end else if (r_cmd.kind == K_READ) begin
                    mem_re = r_cmd.idx_ok;
                    mem_ra = CA_W'(r_cmd.cell_index);
                end else if (is_put && r_enabled) begin
                    if (r_cmd.kind == K_GLYPH) begin
                        mem_we = 1'b1;
                        mem_wa = cur_pos;
                        mem_wd = {r_color, r_cmd.char_code};
                    end
                    n_col = wrap ? '0 : COL_W'(step_col);
                    if (scroll) begin
                        n_row     = ROW_LAST;
                        n_cnt     = '0;
                        n_cp_pend = 1'b0;
                        n_state   = S_COPY;
                    end else begin
                        n_row = ROW_W'(wrap_row);
                    end
                end
            end
            S_COPY: begin
                // Read one row ahead, write the cell read last cycle
                mem_re    = 1'b1;
                mem_we    = r_cp_pend;
                mem_wa    = r_cp_addr;
                mem_wd    = r_rd_data;
                n_cp_addr = r_cnt;
                n_cp_pend = 1'b1;
                if (r_cnt == COPY_LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                mem_we  = 1'b1;
                mem_wa  = r_cp_addr;
                mem_wd  = r_rd_data;
                n_cnt   = BLANK_FIRST;
                n_state = S_BLANK;
            end
            S_BLANK: begin
                mem_we = 1'b1;
                if (r_cnt == CELL_LAST) begin
                    n_state = S_RESULT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    if (!i_q_status.empty) begin
                        o_pop   = 1'b1;
                        n_cmd   = i_cmd;
                        n_state = S_EXEC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_enabled   <= 1'b0;
            r_cp_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_color     <= COLOR_RESET;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_enabled   <= n_enabled;
            r_cp_pend   <= n_cp_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_color <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_cnt     <= n_cnt;
        r_cp_addr <= n_cp_addr;
        if (load_out) begin
            r_out_pos  <= POS_W'(cur_pos);
            r_out_cell <= (r_cmd.kind == K_READ && r_cmd.idx_ok) ? r_rd_data : '0;
        end
    end

    // Cell store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_out_pos;
    assign o_cell_value      = r_out_cell;

endmodule

`default_nettype wire

### rtl/text_console_cursor_engine_top.sv
// Text console engine: a COLUMNS x ROWS store of character/attribute cells with a cursor.
// Each accepted transaction (put character, clear screen, read cell) returns one result
// with the linear cursor position and, for a read, the cell. Newline, carriage return,
// tab and printable bytes move the cursor; a row past the last one scrolls the store up.
// Put characters are ignored until the first clear, and reading a cell before the first
// clear returns unspecified data. A clear and a put that scrolls walk the whole store through
// the single write port of the cell store (one cell copied or blanked per cycle). Up to four
// commands queue ahead of the sequencer, and the result register holds one result.
// Depends on tcc_pkg, tcc_front, tcc_queue and tcc_back.
`default_nettype none

module text_console_cursor_engine_top
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [COLOR_W-1:0]    cfg_data,       // text_color [7:0]
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // char_code [7:0], cell_index [18:8]
    input  wire logic [OP_W-1:0]       s_axis_tuser,   // op [1:0]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata    // cursor_position [10:0], cell_value [26:11]
);

    localparam int CELLS = COLUMNS * ROWS;

    t_cmd                front_cmd;
    t_cmd                head_cmd;
    t_q_status           q_status;
    logic                push;
    logic                pop;
    logic [POS_W-1:0]    cursor_position;
    logic [CELL_W-1:0]   cell_value;

    assign cfg_ready = 1'b1;

    tcc_front #(
        .CELLS (CELLS)
    ) u_front (
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata),
        .i_user     (s_axis_tuser),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    tcc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    tcc_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_data        (cfg_data),
        .i_cmd             (head_cmd),
        .i_q_status        (q_status),
        .o_pop             (pop),
        .o_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .o_cursor_position (cursor_position),
        .o_cell_value      (cell_value)
    );

    // Pack the result fields, lowest first
    assign m_axis_tdata = {{(OUT_DATA_W-POS_W-CELL_W){1'b0}}, cell_value, cursor_position};

endmodule

`default_nettype wire

### rtl/tcc_checker.sv
// Port-level checks for the text console engine, bound to its top level.
// Depends on tcc_pkg and text_console_cursor_engine_top.
`default_nettype none

module tcc_checker
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CELLS = COLUMNS * ROWS;

    logic [3:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Track transactions accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_acc && !out_acc) begin
            r_pending <= r_pending + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (CELLS > 2048) || (int'(m_axis_tdata[POS_W-1:0]) < CELLS))
        else $error("cursor position outside the screen");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != '0)
        else $error("result without an accepted transaction");

endmodule

bind text_console_cursor_engine_top tcc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcc_checker (.*);

`default_nettype wire

### tb/console_checker.sv
// Scoreboard for the text console cursor engine: watches the config, input and result
// channels, keeps a shadow screen and cursor, predicts each result and compares it.
// Depends on tcc_pkg for field widths, operation codes and control characters.
`timescale 1ns / 100ps

module console_checker
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [COLOR_W-1:0]    i_cfg_data,     // text_color [7:0]
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic [IN_DATA_W-1:0]  i_in_data,      // char_code [7:0], cell_index [18:8]
    input  wire logic [OP_W-1:0]       i_in_user,      // op [1:0]
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [OUT_DATA_W-1:0] i_out_data,     // cursor_position [10:0], cell_value [26:11]
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_scrolls
);

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_word;
    } t_console_result;

    // Shadow of the console state
    logic [CELL_W-1:0]  shadow_cells [CELLS];
    int unsigned        cur_col;
    int unsigned        cur_row;
    bit                 console_on;
    logic [COLOR_W-1:0] attr;

    t_console_result    expected_results [$];
    t_console_result    predicted;
    t_console_result    oldest;
    int                 fails;
    int                 checked;
    int                 scrolls;

    // Print one line per mismatch and count every one
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        fails++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic logic [CELL_W-1:0] blank_cell();
        return {attr, CH_BLANK};
    endfunction

    // Move rows up by one, blank the bottom row, park the cursor on it
    task automatic scroll_screen();
        for (int i = 0; i < CELLS - COLUMNS; i++)
            shadow_cells[i] = shadow_cells[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            shadow_cells[i] = blank_cell();
        cur_row = ROWS - 1;
        scrolls++;
    endtask

    task automatic clear_screen();
        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = blank_cell();
        cur_col    = 0;
        cur_row    = 0;
        console_on = 1'b1;
    endtask

    // Put one byte: control characters move the cursor, others are stored
    task automatic place_char(input logic [CHAR_W-1:0] ch);
        int unsigned lin;
        if (!console_on)
            return;
        if (ch == CH_NEWLINE) begin
            cur_row++;
            cur_col = 0;
        end else if (ch == CH_RETURN) begin
            cur_col = 0;
        end else if (ch == CH_TAB) begin
            cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
        end else begin
            lin = cur_row * COLUMNS + cur_col;
            if (lin < CELLS) begin
                shadow_cells[lin] = {attr, ch};
                cur_col++;
            end
        end
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS)
            scroll_screen();
    endtask

    // Advance the shadow by one command and work out its result
    task automatic apply_command(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                 input logic [IDX_W-1:0] idx, output t_console_result res);
        logic [CELL_W-1:0] cell_word;
        int unsigned       lin;
        cell_word = '0;
        case (op)
            OP_PUT:   place_char(ch);
            OP_CLEAR: clear_screen();
            OP_READ: begin
                if (idx < CELLS)
                    cell_word = shadow_cells[idx];
            end
            default: ;
        endcase
        lin            = cur_row * COLUMNS + cur_col;
        res.cursor_pos = lin[POS_W-1:0];
        res.cell_word  = cell_word;
    endtask

    // Check results first (they belong to earlier commands), then predict new ones
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_col    = 0;
            cur_row    = 0;
            console_on = 1'b0;
            attr       = COLOR_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                attr = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding", i_out_data, 0);
                end else begin
                    oldest = expected_results.pop_front();
                    checked++;
                    if (i_out_data[POS_W-1:0] !== oldest.cursor_pos)
                        report_mismatch("cursor_position", i_out_data[POS_W-1:0],
                                        oldest.cursor_pos);
                    if (i_out_data[POS_W+CELL_W-1:POS_W] !== oldest.cell_word)
                        report_mismatch("cell_value", i_out_data[POS_W+CELL_W-1:POS_W],
                                        oldest.cell_word);
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_command(i_in_user, i_in_data[CHAR_W-1:0],
                              i_in_data[CHAR_W+IDX_W-1:CHAR_W], predicted);
                expected_results.push_back(predicted);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_scrolls    <= scrolls;
    end

endmodule

### tb/text_console_cursor_engine_top_tb.sv
// Testbench top for the text console cursor engine: drives reset, color writes and
// command transactions with random idling on both sides, and gives the verdict.
// Depends on tcc_pkg, text_console_cursor_engine_top and console_checker.
`timescale 1ns / 100ps

module text_console_cursor_engine_top_tb;
    import tcc_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 325;
    localparam int SETTLE       = 40;
    // Every command a full-store walk plus both sides' longest idle, three times over
    localparam longint LIMIT_CYCLES = 64'd13_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [COLOR_W-1:0]    cfg_data = '0;          // text_color [7:0]
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;      // char_code [7:0], cell_index [18:8]
    logic [OP_W-1:0]       s_axis_tuser = '0;      // op [1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;           // cursor_position [10:0], cell_value [26:11]

    int     fail_count;
    int     pending;
    int     checked;
    int     scrolls;
    longint cycle_count = 0;

    int     send_quiet = 0;
    int     recv_quiet = 0;
    int     n_put, n_clear, n_read, n_none, n_colors;

    text_console_cursor_engine_top #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    console_checker #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_scrolls   (scrolls)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hard stop if the run hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("text_console_cursor_engine_top verification failed");
            $finish;
        end
    end

    // Idle cycles before the next transaction, with occasional stretches of none
    function automatic int draw_idle(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Result side: wait for an offered result, stall, then accept it
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = draw_idle(recv_quiet);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
                while (!m_axis_tvalid)
                    @(posedge i_clk);
                repeat (stall - 1) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid)
                @(posedge i_clk);
        end
    end

    // Offer one command transaction; valid stays high into the next one when no gap
    task automatic send_command(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx);
        int gap;
        gap = draw_idle(send_quiet);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W - IDX_W - CHAR_W){1'b0}}, idx, ch};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        case (op)
            OP_PUT:   n_put++;
            OP_CLEAR: n_clear++;
            OP_READ:  n_read++;
            default:  n_none++;
        endcase
    endtask

    // Drop valid and hold until every outstanding result has been accepted
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_color(input logic [COLOR_W-1:0] color);
        cfg_valid <= 1'b1;
        cfg_data  <= color;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
        n_colors++;
    endtask

    // One random command: mostly printable text, some control bytes, reads and clears
    task automatic random_command();
        int                 pick;
        logic [CHAR_W-1:0]  ch;
        logic [IDX_W-1:0]   idx;
        pick = $urandom_range(0, 99);
        ch   = $urandom_range(0, 255);
        idx  = $urandom_range(0, 2047);
        if (pick < 1) begin
            send_command(OP_CLEAR, ch, idx);
        end else if (pick < 6) begin
            send_command(OP_PUT, CH_NEWLINE, idx);
        end else if (pick < 8) begin
            send_command(OP_PUT, CH_RETURN, idx);
        end else if (pick < 11) begin
            send_command(OP_PUT, CH_TAB, idx);
        end else if (pick < 13) begin
            send_command(OP_NONE, ch, idx);
        end else if (pick < 28) begin
            if ($urandom_range(0, 9) != 0)
                idx = $urandom_range(0, CELLS - 1);
            else
                idx = $urandom_range(CELLS, 2047);
            send_command(OP_READ, ch, idx);
        end else begin
            send_command(OP_PUT, ch, idx);
        end
    endtask

    initial begin
        logic [COLOR_W-1:0] color;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ignored puts before the first clear, then field extremes at reset color
        send_command(OP_PUT,   8'h41,      11'd0);
        send_command(OP_NONE,  8'hFF,      11'd2047);
        send_command(OP_CLEAR, 8'h00,      11'd0);
        send_command(OP_READ,  8'h00,      11'd0);
        send_command(OP_READ,  8'hFF,      11'(CELLS - 1));
        send_command(OP_READ,  8'h00,      11'(CELLS));
        send_command(OP_READ,  8'hFF,      11'd2047);
        send_command(OP_PUT,   8'h00,      11'd2047);
        send_command(OP_PUT,   8'hFF,      11'd0);
        send_command(OP_PUT,   8'h80,      11'd0);
        send_command(OP_PUT,   8'h41,      11'd0);
        send_command(OP_PUT,   CH_TAB,     11'd0);
        send_command(OP_PUT,   8'h42,      11'd0);
        send_command(OP_PUT,   CH_RETURN,  11'd0);
        send_command(OP_PUT,   CH_NEWLINE, 11'd0);
        send_command(OP_NONE,  8'h00,      11'd0);
        send_command(OP_READ,  8'h00,      11'd1);
        send_command(OP_READ,  8'h00,      11'd3);
        send_command(OP_READ,  8'h00,      11'd8);

        // Random phases, each under its own color written while idle
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       color = 8'h00;
                1:       color = 8'hFF;
                3:       color = 8'h0F;
                4:       color = 8'hF0;
                default: color = $urandom_range(0, 255);
            endcase
            drain_results();
            write_color(color);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_command();
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d puts, %0d clears, %0d reads, %0d no-ops under %0d written colors",
                 n_put, n_clear, n_read, n_none, n_colors);
        $display("compared %0d results; the screen scrolled %0d times", checked, scrolls);
        if (fail_count == 0 && pending == 0)
            $display("text_console_cursor_engine_top verification clean");
        else
            $display("text_console_cursor_engine_top verification failed");
        $finish;
    end

endmodule
